// File: sv/rycg_pkg.sv
// Shared types, fixed-point coefficients and saturation helpers for the
// RGB / YCbCr / gray converter pipeline. No dependencies.
package rycg_pkg;

  localparam int COEF_FRAC_BITS = 14;

  // Widths of the intermediate values, all derived from the fraction width.
  localparam int KW  = COEF_FRAC_BITS + 2;       // signed coefficient
  localparam int PW  = COEF_FRAC_BITS + 8;       // unsigned luma product
  localparam int SPW = COEF_FRAC_BITS + 10;      // signed chroma product
  localparam int YW  = COEF_FRAC_BITS + 10;      // luma sum in Q.F
  localparam int CW  = COEF_FRAC_BITS + 11;      // signed channel in Q.F
  localparam int DW  = 2 * COEF_FRAC_BITS + 13;  // signed chroma in Q.2F

  // Coefficients in millionths, rounded half up to Q.F.
  localparam longint K_YR_L  = ((longint'(299000)  << COEF_FRAC_BITS) + 500000) / 1000000;
  localparam longint K_YG_L  = ((longint'(587000)  << COEF_FRAC_BITS) + 500000) / 1000000;
  localparam longint K_YB_L  = ((longint'(114000)  << COEF_FRAC_BITS) + 500000) / 1000000;
  localparam longint K_CB_L  = ((longint'(564334)  << COEF_FRAC_BITS) + 500000) / 1000000;
  localparam longint K_CR_L  = ((longint'(713267)  << COEF_FRAC_BITS) + 500000) / 1000000;
  localparam longint K_RCR_L = ((longint'(1402000) << COEF_FRAC_BITS) + 500000) / 1000000;
  localparam longint K_GCB_L = ((longint'(344140)  << COEF_FRAC_BITS) + 500000) / 1000000;
  localparam longint K_GCR_L = ((longint'(714140)  << COEF_FRAC_BITS) + 500000) / 1000000;
  localparam longint K_BCB_L = ((longint'(1772000) << COEF_FRAC_BITS) + 500000) / 1000000;

  localparam logic [KW-1:0] K_YR = KW'(K_YR_L);
  localparam logic [KW-1:0] K_YG = KW'(K_YG_L);
  localparam logic [KW-1:0] K_YB = KW'(K_YB_L);
  localparam logic signed [KW-1:0] K_CB  = KW'(K_CB_L);
  localparam logic signed [KW-1:0] K_CR  = KW'(K_CR_L);
  localparam logic signed [KW-1:0] K_RCR = KW'(K_RCR_L);
  localparam logic signed [KW-1:0] K_GCB = KW'(K_GCB_L);
  localparam logic signed [KW-1:0] K_GCR = KW'(K_GCR_L);
  localparam logic signed [KW-1:0] K_BCB = KW'(K_BCB_L);

  // Chroma offset of 128 in Q.2F.
  localparam logic signed [DW:0] HALF_Q2 = (DW + 1)'(128) << (2 * COEF_FRAC_BITS);

  // floor(s / 3) for s up to 765 as a multiply by a reciprocal.
  localparam logic [10:0] DIV3_MUL   = 11'd683;
  localparam int          DIV3_SHIFT = 11;

  localparam logic [1:0] ADDR_MODE = 2'd0;

  typedef enum logic [1:0] {
    MODE_RGB2YCC   = 2'd0,
    MODE_YCC2RGB   = 2'd1,
    MODE_GRAY_MEAN = 2'd2,
    MODE_GRAY_LUMA = 2'd3
  } mode_e;

  typedef struct packed {
    mode_e                  mode;
    logic [7:0]             a;
    logic [7:0]             c;
    logic [PW-1:0]          p_yr;
    logic [PW-1:0]          p_yg;
    logic [PW-1:0]          p_yb;
    logic signed [SPW-1:0]  p_rcr;
    logic signed [SPW-1:0]  p_gcb;
    logic signed [SPW-1:0]  p_gcr;
    logic signed [SPW-1:0]  p_bcb;
    logic [9:0]             sum3;
  } prod_t;

  typedef struct packed {
    mode_e                 mode;
    logic [7:0]            a;
    logic [7:0]            c;
    logic [YW-1:0]         yq;
    logic signed [CW-1:0]  r;
    logic signed [CW-1:0]  g;
    logic signed [CW-1:0]  b;
    logic [7:0]            mean8;
  } sum_t;

  typedef struct packed {
    mode_e                 mode;
    logic [7:0]            y8;
    logic [7:0]            r8;
    logic [7:0]            g8;
    logic [7:0]            b8;
    logic [7:0]            mean8;
    logic signed [DW-1:0]  pcb;
    logic signed [DW-1:0]  pcr;
  } chr_t;

  // Unsigned luma in Q.F, floored and saturated to 255.
  function automatic logic [7:0] sat_u(input logic [YW-1:0] v);
    logic [YW-1:0] u;
    u = v >> COEF_FRAC_BITS;
    return (u > YW'(255)) ? 8'd255 : u[7:0];
  endfunction

  // Signed channel in Q.F: negative gives 0, else floored and saturated.
  function automatic logic [7:0] sat_q1(input logic signed [CW-1:0] v);
    logic [CW-1:0] u;
    u = unsigned'(v) >> COEF_FRAC_BITS;
    if (v <= 0) begin
      return 8'd0;
    end
    return (u > CW'(255)) ? 8'd255 : u[7:0];
  endfunction

  // Chroma in Q.2F with the offset of 128 added, then clamped to 0..255.
  function automatic logic [7:0] sat_q2(input logic signed [DW-1:0] p);
    logic signed [DW:0] v;
    logic [DW:0]        u;
    v = (DW + 1)'(p) + HALF_Q2;
    u = unsigned'(v) >> (2 * COEF_FRAC_BITS);
    if (v <= 0) begin
      return 8'd0;
    end
    return (u > (DW + 1)'(255)) ? 8'd255 : u[7:0];
  endfunction

endpackage

// File: sv/rycg_prod.sv
// First pipeline stage: the coefficient products and the three-channel sum.
// Depends on rycg_pkg.
module rycg_prod (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  rycg_pkg::mode_e      mode_i,
  input  logic [7:0]           a_i,
  input  logic [7:0]           b_i,
  input  logic [7:0]           c_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output rycg_pkg::prod_t      data_o
);

  logic                valid_q;
  rycg_pkg::prod_t     data_d, data_q;
  logic signed [8:0]   db, dc;

  assign ready_o = ~valid_q | ready_i;

  always_comb begin
    db = $signed({1'b0, b_i}) - 9'sd128;
    dc = $signed({1'b0, c_i}) - 9'sd128;
    data_d.mode  = mode_i;
    data_d.a     = a_i;
    data_d.c     = c_i;
    data_d.p_yr  = rycg_pkg::PW'(a_i) * rycg_pkg::PW'(rycg_pkg::K_YR);
    data_d.p_yg  = rycg_pkg::PW'(b_i) * rycg_pkg::PW'(rycg_pkg::K_YG);
    data_d.p_yb  = rycg_pkg::PW'(c_i) * rycg_pkg::PW'(rycg_pkg::K_YB);
    data_d.p_rcr = rycg_pkg::SPW'(dc) * rycg_pkg::SPW'(rycg_pkg::K_RCR);
    data_d.p_gcb = rycg_pkg::SPW'(db) * rycg_pkg::SPW'(rycg_pkg::K_GCB);
    data_d.p_gcr = rycg_pkg::SPW'(dc) * rycg_pkg::SPW'(rycg_pkg::K_GCR);
    data_d.p_bcb = rycg_pkg::SPW'(db) * rycg_pkg::SPW'(rycg_pkg::K_BCB);
    data_d.sum3  = 10'(a_i) + 10'(b_i) + 10'(c_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: sv/rycg_sum.sv
// Second pipeline stage: luma sum, inverse-transform channel sums and the
// gray mean by reciprocal multiply. Depends on rycg_pkg.
module rycg_sum (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  rycg_pkg::prod_t  data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output rycg_pkg::sum_t   data_o
);

  logic                                valid_q;
  rycg_pkg::sum_t                      data_d, data_q;
  logic signed [rycg_pkg::CW-1:0]      cq;
  logic [20:0]                         mean_prod;

  assign ready_o = ~valid_q | ready_i;

  always_comb begin
    cq = $signed({3'b000, data_i.a, {rycg_pkg::COEF_FRAC_BITS{1'b0}}});
    mean_prod = 21'(data_i.sum3) * 21'(rycg_pkg::DIV3_MUL);
    data_d.mode  = data_i.mode;
    data_d.a     = data_i.a;
    data_d.c     = data_i.c;
    data_d.yq    = rycg_pkg::YW'(data_i.p_yr) + rycg_pkg::YW'(data_i.p_yg)
                 + rycg_pkg::YW'(data_i.p_yb);
    data_d.r     = cq + rycg_pkg::CW'(data_i.p_rcr);
    data_d.g     = cq - rycg_pkg::CW'(data_i.p_gcb) - rycg_pkg::CW'(data_i.p_gcr);
    data_d.b     = cq + rycg_pkg::CW'(data_i.p_bcb);
    data_d.mean8 = mean_prod[rycg_pkg::DIV3_SHIFT +: 8];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: sv/rycg_chroma.sv
// Third pipeline stage: chroma products from the luma difference and
// saturation of the luma and inverse-transform channels. Depends on rycg_pkg.
module rycg_chroma (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  rycg_pkg::sum_t   data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output rycg_pkg::chr_t   data_o
);

  logic                            valid_q;
  rycg_pkg::chr_t                  data_d, data_q;
  logic signed [rycg_pkg::CW-1:0]  dcb, dcr;

  assign ready_o = ~valid_q | ready_i;

  always_comb begin
    // Blue and red scaled to Q.F, minus the exact luma.
    dcb = $signed({3'b000, data_i.c, {rycg_pkg::COEF_FRAC_BITS{1'b0}}})
        - $signed({1'b0, data_i.yq});
    dcr = $signed({3'b000, data_i.a, {rycg_pkg::COEF_FRAC_BITS{1'b0}}})
        - $signed({1'b0, data_i.yq});
    data_d.mode  = data_i.mode;
    data_d.y8    = rycg_pkg::sat_u(data_i.yq);
    data_d.r8    = rycg_pkg::sat_q1(data_i.r);
    data_d.g8    = rycg_pkg::sat_q1(data_i.g);
    data_d.b8    = rycg_pkg::sat_q1(data_i.b);
    data_d.mean8 = data_i.mean8;
    data_d.pcb   = rycg_pkg::DW'(dcb) * rycg_pkg::DW'(rycg_pkg::K_CB);
    data_d.pcr   = rycg_pkg::DW'(dcr) * rycg_pkg::DW'(rycg_pkg::K_CR);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: sv/rgb_ycbcr_gray_converter.sv
// Top level of the colour converter: APB mode register, three arithmetic
// stages and the output register. Depends on rycg_pkg, rycg_prod, rycg_sum
// and rycg_chroma.
// An accepted input passes the product, sum, chroma and output registers.
// Throughput: one pixel per cycle unless the output stalls; each of the four
// stages holds one pixel and advances whenever the stage after it is empty or
// moving. Reset clears every stage's valid bit and sets mode to RGB to YCbCr.
module rgb_ycbcr_gray_converter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // chan_first_in [7:0], chan_second_in [15:8], chan_third_in [23:16]
  input  logic [23:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // chan_first_out [7:0], chan_second_out [15:8], chan_third_out [23:16]
  output logic [23:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  rycg_pkg::mode_e  mode_q;
  logic             prod_valid, prod_ready;
  logic             sum_valid, sum_ready;
  logic             chr_valid, chr_ready;
  rycg_pkg::prod_t  prod_data;
  rycg_pkg::sum_t   sum_data;
  rycg_pkg::chr_t   chr_data;
  logic             out_valid_q;
  logic [23:0]      out_data_d, out_data_q;
  logic [7:0]       cb8, cr8;

  assign pready = 1'b1;
  assign prdata = {30'd0, mode_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= rycg_pkg::MODE_RGB2YCC;
    end else if (psel && penable && pwrite && paddr == rycg_pkg::ADDR_MODE) begin
      mode_q <= rycg_pkg::mode_e'(pwdata[1:0]);
    end
  end

  rycg_prod u_prod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .mode_i  (mode_q),
    .a_i     (s_axis_tdata[7:0]),
    .b_i     (s_axis_tdata[15:8]),
    .c_i     (s_axis_tdata[23:16]),
    .valid_o (prod_valid),
    .ready_i (prod_ready),
    .data_o  (prod_data)
  );

  rycg_sum u_sum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prod_valid),
    .ready_o (prod_ready),
    .data_i  (prod_data),
    .valid_o (sum_valid),
    .ready_i (sum_ready),
    .data_o  (sum_data)
  );

  rycg_chroma u_chroma (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sum_valid),
    .ready_o (sum_ready),
    .data_i  (sum_data),
    .valid_o (chr_valid),
    .ready_i (chr_ready),
    .data_o  (chr_data)
  );

  // Final stage: chroma offset and clamp, then selection by mode.
  assign chr_ready = ~out_valid_q | m_axis_tready;

  always_comb begin
    cb8 = rycg_pkg::sat_q2(chr_data.pcb);
    cr8 = rycg_pkg::sat_q2(chr_data.pcr);
    case (chr_data.mode)
      rycg_pkg::MODE_RGB2YCC:   out_data_d = {cr8, cb8, chr_data.y8};
      rycg_pkg::MODE_YCC2RGB:   out_data_d = {chr_data.b8, chr_data.g8, chr_data.r8};
      rycg_pkg::MODE_GRAY_MEAN: out_data_d = {3{chr_data.mean8}};
      rycg_pkg::MODE_GRAY_LUMA: out_data_d = {3{chr_data.y8}};
      default:                  out_data_d = {3{chr_data.y8}};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (chr_ready) begin
      out_valid_q <= chr_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (chr_valid && chr_ready) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// File: sv/rycg_checker.sv
// Port-level checks for the colour converter, bound to its top level.
// Depends on rycg_pkg and rgb_ycbcr_gray_converter.
module rycg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [23:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [1:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  // A result transaction that is stalled stays offered.
  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output valid dropped while stalled");

  // A stalled result keeps its data.
  a_out_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output data changed while stalled");

  // Nothing is offered straight after reset.
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // A taken output lets the whole pipeline take an input transaction.
  a_ready_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled although output is free");

  // The mode register reads back what was written.
  a_mode_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready && paddr == rycg_pkg::ADDR_MODE
    |=> prdata == {30'd0, $past(pwdata[1:0])})
    else $error("mode register read-back mismatch");

endmodule

bind rgb_ycbcr_gray_converter rycg_checker u_rycg_checker (.*);

// File: test/tb.sv
`timescale 1ns / 1ps
// Testbench for rgb_ycbcr_gray_converter: drives pixel transactions and mode writes,
// predicts every converted pixel and checks the output stream in order.
// Depends on rycg_pkg and the converter RTL.
module tb;

  localparam int FRAC           = rycg_pkg::COEF_FRAC_BITS;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 300;
  localparam int PHASES         = 8;
  localparam int PHASE_PIXELS   = 200;
  localparam int STIM_ROWS      = 22;

  // Conversion coefficients, round half up of c * 2^FRAC.
  localparam longint KQ_YR  = ((longint'(299000)  << FRAC) + 500000) / 1000000;
  localparam longint KQ_YG  = ((longint'(587000)  << FRAC) + 500000) / 1000000;
  localparam longint KQ_YB  = ((longint'(114000)  << FRAC) + 500000) / 1000000;
  localparam longint KQ_CB  = ((longint'(564334)  << FRAC) + 500000) / 1000000;
  localparam longint KQ_CR  = ((longint'(713267)  << FRAC) + 500000) / 1000000;
  localparam longint KQ_RCR = ((longint'(1402000) << FRAC) + 500000) / 1000000;
  localparam longint KQ_GCB = ((longint'(344140)  << FRAC) + 500000) / 1000000;
  localparam longint KQ_GCR = ((longint'(714140)  << FRAC) + 500000) / 1000000;
  localparam longint KQ_BCB = ((longint'(1772000) << FRAC) + 500000) / 1000000;
  localparam longint CHROMA_OFFSET = longint'(128) << (2 * FRAC);

  typedef struct {
    rycg_pkg::mode_e mode;
    logic [7:0]      a, b, c;
    bit              typed;
    logic [7:0]      ea, eb, ec;
  } stim_row_t;

  // Directed pixels; typed rows carry their expected output, the rest use the predictor.
  stim_row_t stim_table [STIM_ROWS] = '{
    '{rycg_pkg::MODE_RGB2YCC,   8'd0,   8'd0,   8'd0,   1'b1, 8'd0,   8'd128, 8'd128},
    '{rycg_pkg::MODE_RGB2YCC,   8'd255, 8'd255, 8'd255, 1'b1, 8'd255, 8'd128, 8'd128},
    '{rycg_pkg::MODE_RGB2YCC,   8'd255, 8'd0,   8'd0,   1'b0, 8'd0,   8'd0,   8'd0},
    '{rycg_pkg::MODE_RGB2YCC,   8'd0,   8'd255, 8'd0,   1'b0, 8'd0,   8'd0,   8'd0},
    '{rycg_pkg::MODE_RGB2YCC,   8'd0,   8'd0,   8'd255, 1'b0, 8'd0,   8'd0,   8'd0},
    '{rycg_pkg::MODE_RGB2YCC,   8'd0,   8'd255, 8'd255, 1'b0, 8'd0,   8'd0,   8'd0},
    '{rycg_pkg::MODE_RGB2YCC,   8'd255, 8'd255, 8'd0,   1'b0, 8'd0,   8'd0,   8'd0},
    '{rycg_pkg::MODE_YCC2RGB,   8'd0,   8'd128, 8'd128, 1'b1, 8'd0,   8'd0,   8'd0},
    '{rycg_pkg::MODE_YCC2RGB,   8'd255, 8'd128, 8'd128, 1'b1, 8'd255, 8'd255, 8'd255},
    '{rycg_pkg::MODE_YCC2RGB,   8'd255, 8'd255, 8'd255, 1'b0, 8'd0,   8'd0,   8'd0},
    '{rycg_pkg::MODE_YCC2RGB,   8'd0,   8'd0,   8'd0,   1'b0, 8'd0,   8'd0,   8'd0},
    '{rycg_pkg::MODE_YCC2RGB,   8'd128, 8'd0,   8'd255, 1'b0, 8'd0,   8'd0,   8'd0},
    '{rycg_pkg::MODE_YCC2RGB,   8'd128, 8'd255, 8'd0,   1'b0, 8'd0,   8'd0,   8'd0},
    '{rycg_pkg::MODE_GRAY_MEAN, 8'd0,   8'd0,   8'd0,   1'b1, 8'd0,   8'd0,   8'd0},
    '{rycg_pkg::MODE_GRAY_MEAN, 8'd255, 8'd255, 8'd255, 1'b1, 8'd255, 8'd255, 8'd255},
    '{rycg_pkg::MODE_GRAY_MEAN, 8'd1,   8'd1,   8'd0,   1'b1, 8'd0,   8'd0,   8'd0},
    '{rycg_pkg::MODE_GRAY_MEAN, 8'd2,   8'd2,   8'd2,   1'b1, 8'd2,   8'd2,   8'd2},
    '{rycg_pkg::MODE_GRAY_MEAN, 8'd255, 8'd255, 8'd254, 1'b1, 8'd254, 8'd254, 8'd254},
    '{rycg_pkg::MODE_GRAY_LUMA, 8'd0,   8'd0,   8'd0,   1'b1, 8'd0,   8'd0,   8'd0},
    '{rycg_pkg::MODE_GRAY_LUMA, 8'd255, 8'd255, 8'd255, 1'b1, 8'd255, 8'd255, 8'd255},
    '{rycg_pkg::MODE_GRAY_LUMA, 8'd0,   8'd255, 8'd0,   1'b0, 8'd0,   8'd0,   8'd0},
    '{rycg_pkg::MODE_GRAY_LUMA, 8'd170, 8'd85,  8'd51,  1'b0, 8'd0,   8'd0,   8'd0}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // chan_first_in [7:0], chan_second_in [15:8], chan_third_in [23:16]
  logic [23:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // chan_first_out [7:0], chan_second_out [15:8], chan_third_out [23:16]
  logic [23:0] m_axis_tdata;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  logic [23:0]     pixel_expect_q [$];
  rycg_pkg::mode_e active_mode;
  int              idle_rate      = 0;
  bit              long_hold_go   = 1'b0;
  int              fail_count     = 0;
  int              pixels_sent    = 0;
  int              pixels_checked = 0;
  int              mode_writes    = 0;

  rgb_ycbcr_gray_converter u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #6 clk_i = ~clk_i;

  // Floor of v / 2^sh, clamped to 0..255.
  function automatic logic [7:0] clamp_level(longint v, int sh);
    longint q;
    if (v <= 0) begin
      return 8'd0;
    end
    q = v >>> sh;
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  function automatic logic [23:0] convert_pixel(rycg_pkg::mode_e m, logic [23:0] px);
    longint     a, b, c, yq;
    logic [7:0] o0, o1, o2;
    a = px[7:0];
    b = px[15:8];
    c = px[23:16];
    case (m)
      rycg_pkg::MODE_RGB2YCC: begin
        yq = KQ_YR * a + KQ_YG * b + KQ_YB * c;
        o0 = clamp_level(yq, FRAC);
        o1 = clamp_level(CHROMA_OFFSET + KQ_CB * ((c <<< FRAC) - yq), 2 * FRAC);
        o2 = clamp_level(CHROMA_OFFSET + KQ_CR * ((a <<< FRAC) - yq), 2 * FRAC);
      end
      rycg_pkg::MODE_YCC2RGB: begin
        yq = a <<< FRAC;
        o0 = clamp_level(yq + KQ_RCR * (c - 128), FRAC);
        o1 = clamp_level(yq - KQ_GCB * (b - 128) - KQ_GCR * (c - 128), FRAC);
        o2 = clamp_level(yq + KQ_BCB * (b - 128), FRAC);
      end
      rycg_pkg::MODE_GRAY_MEAN: begin
        yq = (a + b + c) / 3;
        o0 = yq[7:0];
        o1 = o0;
        o2 = o0;
      end
      default: begin
        o0 = clamp_level(KQ_YR * a + KQ_YG * b + KQ_YB * c, FRAC);
        o1 = o0;
        o2 = o0;
      end
    endcase
    return {o2, o1, o0};
  endfunction

  // Channel values lean towards the extremes and mid-scale, where clamping lives.
  function automatic logic [7:0] random_level();
    case ($urandom_range(0, 9))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'($urandom_range(118, 138));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_pixel(input logic [23:0] px, input logic [23:0] want);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    do @(posedge clk_i); while (!s_axis_tready);
    pixel_expect_q.push_back(want);
    pixels_sent++;
    if (idle_rate != 0 && $urandom_range(0, 99) < idle_rate) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
  endtask

  task automatic drain_pipeline();
    s_axis_tvalid <= 1'b0;
    while (pixel_expect_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic apb_access(input bit wr, input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= rycg_pkg::ADDR_MODE;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata   = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_mode_reg(input rycg_pkg::mode_e want);
    logic [31:0] rd;
    apb_access(1'b0, 32'd0, rd);
    if (rd[1:0] !== want) begin
      $display("%0t: mode register read back %0d, expected %0d", $time, rd[1:0], want);
      fail_count++;
    end
  endtask

  // Upper data bits carry junk, which the register must ignore.
  task automatic set_mode(input rycg_pkg::mode_e m, input logic [31:0] junk);
    logic [31:0] rd;
    apb_access(1'b1, {junk[31:2], m}, rd);
    active_mode = m;
    mode_writes++;
    @(posedge clk_i);
    check_mode_reg(m);
  endtask

  // Output side: checks every transaction and stalls at random.
  always @(posedge clk_i) begin : result_sink
    int          stall_cnt;
    bit          long_hold_done;
    logic [23:0] want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pixel_expect_q.size() == 0) begin
        $display("%0t: unexpected pixel, expected none, actual %h", $time, m_axis_tdata);
        fail_count++;
      end else begin
        want = pixel_expect_q.pop_front();
        pixels_checked++;
        for (int k = 0; k < 3; k++) begin
          if (m_axis_tdata[8*k +: 8] !== want[8*k +: 8]) begin
            $display("%0t: channel %0d mismatch, expected %0d, actual %0d",
                     $time, k, want[8*k +: 8], m_axis_tdata[8*k +: 8]);
            fail_count++;
          end
        end
      end
    end
    if (long_hold_go && !long_hold_done) begin
      long_hold_done = 1'b1;
      stall_cnt      = LONG_HOLD;
      m_axis_tready <= 1'b0;
    end else if (stall_cnt > 0) begin
      stall_cnt--;
      m_axis_tready <= 1'b0;
    end else if (idle_rate != 0 && $urandom_range(0, 99) < idle_rate) begin
      stall_cnt      = $urandom_range(0, 8);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
          || (psel && penable)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("[rgb_ycbcr_gray_converter] ERROR");
    $finish;
  end

  initial begin : stimulus
    logic [23:0]     px;
    rycg_pkg::mode_e phase_mode;
    rycg_pkg::mode_e phase_modes [PHASES];
    int              phase_idle  [PHASES];
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 24'd0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= 32'd0;
    active_mode    = rycg_pkg::MODE_RGB2YCC;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_mode_reg(rycg_pkg::MODE_RGB2YCC);

    // Directed part; the first rows run on the reset mode.
    idle_rate = 15;
    foreach (stim_table[i]) begin
      if (stim_table[i].mode != active_mode) begin
        drain_pipeline();
        set_mode(stim_table[i].mode, (i < 10) ? 32'hFFFF_FFFC : 32'd0);
      end
      px = {stim_table[i].c, stim_table[i].b, stim_table[i].a};
      send_pixel(px, stim_table[i].typed ?
                 {stim_table[i].ec, stim_table[i].eb, stim_table[i].ea} :
                 convert_pixel(active_mode, px));
    end

    // Random phases; the long output hold sits in the third, the last has no idling.
    phase_modes = '{rycg_pkg::MODE_YCC2RGB, rycg_pkg::MODE_GRAY_LUMA,
                    rycg_pkg::MODE_RGB2YCC, rycg_pkg::MODE_GRAY_MEAN,
                    rycg_pkg::MODE_RGB2YCC, rycg_pkg::MODE_YCC2RGB,
                    rycg_pkg::MODE_GRAY_MEAN, rycg_pkg::MODE_GRAY_LUMA};
    phase_idle  = '{20, 0, 30, 10, 40, 0, 15, 0};
    for (int p = 0; p < PHASES; p++) begin
      phase_mode = (p >= 4 && p < PHASES - 1) ?
                   rycg_pkg::mode_e'($urandom_range(0, 3)) : phase_modes[p];
      drain_pipeline();
      set_mode(phase_mode, $urandom);
      idle_rate = phase_idle[p];
      if (p == 2) begin
        long_hold_go = 1'b1;
      end
      for (int n = 0; n < PHASE_PIXELS; n++) begin
        px = {random_level(), random_level(), random_level()};
        // YCbCr input that a real RGB pixel would produce.
        if (active_mode == rycg_pkg::MODE_YCC2RGB && $urandom_range(0, 3) == 0) begin
          px = convert_pixel(rycg_pkg::MODE_RGB2YCC, px);
        end
        send_pixel(px, convert_pixel(active_mode, px));
      end
    end

    drain_pipeline();
    repeat (8) @(posedge clk_i);
    $display("Converted %0d pixels, %0d checked, over %0d mode writes in all four modes,",
             pixels_sent, pixels_checked, mode_writes);
    $display("with random stalls on both sides and one long output hold.");
    if (fail_count == 0) begin
      $display("[rgb_ycbcr_gray_converter] OK");
    end else begin
      $display("[rgb_ycbcr_gray_converter] ERROR");
    end
    $finish;
  end

endmodule
